// ===== hw/rtl/nsp_pkg.sv =====
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types and constants of the NMEA sentence parser.
// ----------------------------------------------------------------------------
package nsp_pkg;

  localparam int MAX_FIELDS_DEF = 32;
  localparam int HDR_LEN        = 3;
  localparam int TOKQ_DEPTH     = 4;
  localparam int RESQ_DEPTH     = 2;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  typedef enum logic [1:0] {
    K_BYTE    = 2'd0,
    K_EOF     = 2'd1,
    K_VERDICT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_BADHEX   = 2'd2,
    ST_ABORT    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    MT_UNKNOWN = 3'd0,
    MT_GGA     = 3'd1,
    MT_GLL     = 3'd2,
    MT_GSA     = 3'd3,
    MT_GSV     = 3'd4,
    MT_RMC     = 3'd5,
    MT_VTG     = 3'd6
  } msg_type_t;

  // classified input byte, from front to back
  typedef struct packed {
    logic [7:0] char_val;
    logic       is_dollar;
    logic       is_star;
    logic       is_comma;
    logic       hex_ok;
    logic [3:0] hex_val;
  } token_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [4:0] field_index;
    msg_type_t  msg_type;
    status_t    status;
  } result_t;

endpackage

// ===== hw/rtl/nsp_fifo.sv =====
// ----------------------------------------------------------------------------
// nsp_fifo
// Small first-word fall-through queue; depth is a power of two.
// ----------------------------------------------------------------------------
module nsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/nsp_front.sv =====
// ----------------------------------------------------------------------------
// nsp_front
// Classifies each incoming byte: delimiters and hex digit value.
// ----------------------------------------------------------------------------
module nsp_front (
  input  logic          [7:0] byte_in,
  output nsp_pkg::token_t     tok
);
  import nsp_pkg::*;

  always_comb begin
    tok           = '0;
    tok.char_val  = byte_in;
    tok.is_dollar = (byte_in == CH_DOLLAR);
    tok.is_star   = (byte_in == CH_STAR);
    tok.is_comma  = (byte_in == CH_COMMA);
    case (byte_in) inside
      [8'h30:8'h39]: begin
        tok.hex_ok  = 1'b1;
        tok.hex_val = byte_in[3:0];
      end
      [8'h41:8'h46], [8'h61:8'h66]: begin
        // 'A'..'F' and 'a'..'f' share the low bits 1..6
        tok.hex_ok  = 1'b1;
        tok.hex_val = byte_in[3:0] + 4'd9;
      end
      default: begin
        tok.hex_ok  = 1'b0;
        tok.hex_val = 4'd0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/nsp_back.sv =====
// ----------------------------------------------------------------------------
// nsp_back
// Sentence state machine: field tagging, checksum and header classification.
// ----------------------------------------------------------------------------
module nsp_back #(
  parameter int MAX_FIELDS = nsp_pkg::MAX_FIELDS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  nsp_pkg::token_t  tok,
  input  logic             tok_valid,
  output logic             tok_pop,
  output nsp_pkg::result_t res,
  output logic             res_push,
  input  logic             res_full
);
  import nsp_pkg::*;

  localparam logic [4:0] FIELD_TOP = (MAX_FIELDS - 1 > 31) ? 5'd31 : 5'(MAX_FIELDS - 1);
  localparam logic [2:0] HDR_END   = 3'(2 + HDR_LEN);

  localparam logic [23:0] TYPE_NAMES [6] = '{
    24'h474741, 24'h474C4C, 24'h475341, 24'h475356, 24'h524D43, 24'h565447
  };

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_BODY = 4'b0010,
    PH_HEX1 = 4'b0100,
    PH_HEX2 = 4'b1000
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] running_xor, running_xor_next;
  logic [4:0] field_count, field_count_next;
  logic [2:0] header_position, header_position_next;
  logic [7:0] header_chars [HDR_LEN];
  logic [7:0] header_chars_next [HDR_LEN];
  logic [4:0] high_nibble, high_nibble_next;
  logic       fire;

  function automatic msg_type_t classify(input logic [2:0] pos, input logic [23:0] hdr);
    msg_type_t mt;
    mt = MT_UNKNOWN;
    if (pos >= HDR_END) begin
      for (int t = 0; t < 6; t++) begin
        if (hdr == TYPE_NAMES[t]) begin
          mt = msg_type_t'(3'(t + 1));
        end
      end
    end
    return mt;
  endfunction

  assign fire    = tok_valid & ~res_full;
  assign tok_pop = fire;

  always_comb begin
    phase_next           = phase;
    running_xor_next     = running_xor;
    field_count_next     = field_count;
    header_position_next = header_position;
    header_chars_next    = header_chars;
    high_nibble_next     = high_nibble;
    res                  = '0;
    res.kind             = K_BYTE;
    res.msg_type         = MT_UNKNOWN;
    res.status           = ST_OK;
    res.field_index      = field_count;
    res_push             = 1'b0;

    if (fire) begin
      if (phase != PH_HUNT && tok.is_dollar) begin
        res.kind   = K_VERDICT;
        res.status = ST_ABORT;
        res_push   = 1'b1;
      end
      if (tok.is_dollar) begin
        // restart a sentence, also from the hunt phase
        phase_next           = PH_BODY;
        running_xor_next     = '0;
        field_count_next     = '0;
        header_position_next = '0;
        header_chars_next    = '{default: 8'h00};
        high_nibble_next     = '0;
      end else begin
        case (phase)
          PH_HUNT: begin
            phase_next = PH_HUNT;
          end
          PH_BODY: begin
            res_push = 1'b1;
            if (tok.is_star) begin
              phase_next = PH_HEX1;
              res.kind   = K_EOF;
            end else begin
              running_xor_next = running_xor ^ tok.char_val;
              if (tok.is_comma) begin
                res.kind = K_EOF;
                if (field_count < FIELD_TOP) begin
                  field_count_next = field_count + 5'd1;
                end
              end else begin
                res.data_byte = tok.char_val;
                if (field_count == '0 && header_position < HDR_END) begin
                  if (header_position >= 3'd2) begin
                    header_chars_next[2'(header_position - 3'd2)] = tok.char_val;
                  end
                  header_position_next = header_position + 3'd1;
                end
              end
            end
          end
          PH_HEX1, PH_HEX2: begin
            if (!tok.hex_ok) begin
              phase_next = PH_HUNT;
              res.kind   = K_VERDICT;
              res.status = ST_BADHEX;
              res_push   = 1'b1;
            end else if (phase == PH_HEX1) begin
              high_nibble_next = {1'b1, tok.hex_val};
              phase_next       = PH_HEX2;
            end else begin
              phase_next = PH_HUNT;
              res.kind   = K_VERDICT;
              res_push   = 1'b1;
              if (!high_nibble[4]) begin
                res.status = ST_BADHEX;
              end else if ({high_nibble[3:0], tok.hex_val} != running_xor) begin
                res.status = ST_MISMATCH;
              end else begin
                res.msg_type = classify(header_position,
                                        {header_chars[0], header_chars[1], header_chars[2]});
              end
            end
          end
          default: begin
            phase_next = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      running_xor     <= '0;
      field_count     <= '0;
      header_position <= '0;
      header_chars    <= '{default: 8'h00};
      high_nibble     <= '0;
    end else begin
      phase           <= phase_next;
      running_xor     <= running_xor_next;
      field_count     <= field_count_next;
      header_position <= header_position_next;
      header_chars    <= header_chars_next;
      high_nibble     <= high_nibble_next;
    end
  end

endmodule

// ===== hw/rtl/nmea_sentence_parser.sv =====
// Path: an accepted byte is registered in the token queue; the parser step then
// writes any result for it into the result queue, which drives the result ports.
// Throughput: one byte per cycle while the result queue is not full, limited by the single parser step per cycle.
// Reset: rst clears both queues and returns the parser to hunting for '$'.
// ----------------------------------------------------------------------------
// nmea_sentence_parser
// NMEA 0183 byte stream parser: field tagging, checksum check, type verdict.
// ----------------------------------------------------------------------------
module nmea_sentence_parser #(
  parameter int MAX_FIELDS = nsp_pkg::MAX_FIELDS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] byte_in,
  input  logic       pop,
  output logic       empty,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [4:0] field_index,
  output logic [2:0] msg_type,
  output logic [1:0] status
);
  import nsp_pkg::*;

  localparam logic [4:0] FIELD_TOP = (MAX_FIELDS - 1 > 31) ? 5'd31 : 5'(MAX_FIELDS - 1);

  token_t  tok_in;
  token_t  tok_q;
  logic    tok_empty;
  logic    tok_pop;
  result_t res_d;
  result_t res_q;
  logic    res_push;
  logic    res_full;

  nsp_front u_front (
    .byte_in (byte_in),
    .tok     (tok_in)
  );

  nsp_fifo #(
    .WIDTH ($bits(token_t)),
    .DEPTH (TOKQ_DEPTH)
  ) u_tokq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (tok_in),
    .full  (full),
    .pop   (tok_pop),
    .rdata (tok_q),
    .empty (tok_empty)
  );

  nsp_back #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok_q),
    .tok_valid (~tok_empty),
    .tok_pop   (tok_pop),
    .res       (res_d),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  nsp_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_d),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_q),
    .empty (empty)
  );

  assign kind        = res_q.kind;
  assign data_byte   = res_q.data_byte;
  assign field_index = res_q.field_index;
  assign msg_type    = res_q.msg_type;
  assign status      = res_q.status;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");
  a_field_beat_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != K_VERDICT) |-> (status == ST_OK && msg_type == MT_UNKNOWN))
    else $error("field beat carries verdict information");
  a_data_only_bytes: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != K_BYTE) |-> (data_byte == 8'h00))
    else $error("non-byte beat carries data");
  a_index_saturates: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (field_index <= FIELD_TOP))
    else $error("field index beyond saturation");
`endif

endmodule
